[rtl/hash_checked_transfer_receiver_macros.svh]
// Assertion macros used by the port checker of the transfer receiver.
`ifndef HASH_CHECKED_TRANSFER_RECEIVER_MACROS_SVH
`define HASH_CHECKED_TRANSFER_RECEIVER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HCTR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hctr assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HCTR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hctr assertion failed");

`endif

[rtl/hctr_pkg.sv]
// Package with the types, codes and constants of the transfer receiver.
package hctr_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 65536;
    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    localparam int unsigned IN_DATA_W  = 192;
    localparam int unsigned OUT_DATA_W = 128;
    localparam int unsigned REPORT_SIZE_W = 17;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_CHUNK = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_PEER  = 2'd3
    } item_kind_t;

    // Result kinds.
    localparam logic [1:0] RES_ACK      = 2'd0;
    localparam logic [1:0] RES_REJECTED = 2'd1;
    localparam logic [1:0] RES_DROPPED  = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HASH,
        ST_FINISH
    } seq_state_t;

    // Control of the hash accumulator.
    typedef struct packed {
        logic init;
        logic upd;
    } hash_ctl_t;

endpackage

[rtl/hctr_mem.sv]
// File buffer: one write port and one read port with registered read data.
module hctr_mem #(
    parameter int unsigned DEPTH = hctr_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned AW    = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    import hctr_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/hctr_hash.sv]
// FNV-1a 32 accumulator, one byte per cycle while upd is set.
module hctr_hash (
    input  logic                aclk,
    input  hctr_pkg::hash_ctl_t ctl,
    input  logic [7:0]          data_in,
    output logic [31:0]         hash_out
);
    import hctr_pkg::*;

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] mix;

    // Fold one byte in, then multiply by the prime.
    always_comb begin
        mix = hash_reg ^ {24'd0, data_in};
        hash_next = hash_reg;
        if (ctl.init) begin
            hash_next = HASH_BASIS;
        end else if (ctl.upd) begin
            hash_next = mix * HASH_PRIME;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
    end

    assign hash_out = hash_reg;
endmodule

[rtl/hash_checked_transfer_receiver.sv]
// Receiver of a hash-checked file transfer: control, sequencer and result register.
//
// Input transactions carry begin, chunk byte, done and peer reset items; s_tuser holds
// the kind and s_tlast marks the last byte of a chunk. Results (acknowledgement, begin
// rejected, transfer dropped) leave on the m_ channel from an output register, with
// m_tuser holding the result kind.
// After a chunk byte, a peer reset or a rejected begin the block stays idle for the next item.
// An accepted begin clears the first total_size bytes of the buffer, one byte a
// cycle, before the next item is taken.
// A matching done walks the buffer through the single read port: reads of size bytes,
// a step for the last byte to fold in, an idle step, and the finish state, which loads
// the acknowledgement once the result register is free; only then is the next item
// taken. The hash loop is one multiply per cycle.
// A begin-rejected or transfer-dropped result appears in m_tdata the cycle after the item.
// s_tready is low while a clear or a hash walk runs, and also while a result waits
// and m_tready is low, so a stalled receiver holds the block after one result.
// Reset (aresetn low, synchronous) closes any transfer, empties the result register and
// sets local_id to zero; the buffer contents need no reset, since every accepted begin
// clears the range that the transfer can read. local_id is written by cfg_wr_en and
// cfg_wr_data; the user must write it only while idle, which the block does not enforce.
module hash_checked_transfer_receiver #(
    parameter int unsigned BUFFER_BYTES = hctr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [31:0]                     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // xfer_id, owner_id, purpose, total_size, expected_hash, chunk_offset,
    // chunk_len, data_byte
    input  logic [hctr_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,    // kind
    input  logic                            s_tlast,    // byte_last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // report_xfer_id, ack_ok, ack_sender, report_owner, report_purpose,
    // report_size, zero fill
    output logic [hctr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]                      m_tuser     // result_kind
);
    import hctr_pkg::*;

    localparam int unsigned SIZE_W = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned AW     = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [31:0] BUF_MAX = 32'(BUFFER_BYTES);

    // Input fields.
    logic [31:0] in_xfer, in_owner, in_tsize, in_ehash, in_coff;
    logic [7:0]  in_purpose, in_byte;
    logic [15:0] in_clen;
    item_kind_t  in_kind;

    assign in_xfer    = s_tdata[31:0];
    assign in_owner   = s_tdata[63:32];
    assign in_purpose = s_tdata[71:64];
    assign in_tsize   = s_tdata[103:72];
    assign in_ehash   = s_tdata[135:104];
    assign in_coff    = s_tdata[167:136];
    assign in_clen    = s_tdata[183:168];
    assign in_byte    = s_tdata[191:184];
    assign in_kind    = item_kind_t'(s_tuser);

    // State registers.
    seq_state_t          state_reg, state_next;
    logic                receiving_reg, receiving_next;
    logic [31:0]         cur_xfer_reg, cur_xfer_next;
    logic [31:0]         cur_owner_reg, cur_owner_next;
    logic [7:0]          cur_purpose_reg, cur_purpose_next;
    logic [31:0]         ann_hash_reg, ann_hash_next;
    logic [SIZE_W-1:0]   ann_size_reg, ann_size_next;
    logic [31:0]         rcv_count_reg, rcv_count_next;
    logic [15:0]         chunk_pos_reg, chunk_pos_next;
    logic                chunk_rej_reg, chunk_rej_next;
    logic [31:0]         local_id_reg;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;
    logic                rd_pend_reg, rd_pend_next;

    // Result register.
    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_kind_reg, m_kind_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // Memory and hash controls.
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    hash_ctl_t     hash_ctl;
    logic [31:0]   hash_val;

    // Item logic helpers.
    logic          s_fire, out_free, emit;
    logic [1:0]    emit_kind;
    logic [31:0]   emit_xfer;
    logic [32:0]   byte_addr;
    logic          put_ok, chunk_write;
    logic [32:0]   count_sum;
    logic          last_cnt, ok;

    assign out_free = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign last_cnt = (cnt_reg == ann_size_reg);

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_kind == KIND_BEGIN && in_tsize != 32'd0
                        && in_tsize <= BUF_MAX) begin
                    state_next = ST_CLEAR;
                end else if (s_fire && in_kind == KIND_DONE && receiving_reg
                        && in_xfer == cur_xfer_reg) begin
                    state_next = ST_HASH;
                end
            end
            ST_CLEAR: begin
                if (cnt_reg + SIZE_W'(1) == ann_size_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HASH: begin
                if (last_cnt && !rd_pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, hash reads and hash control.
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        hash_ctl = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = out_free;
                hash_ctl.init = 1'b1;
            end
            ST_CLEAR: begin
                s_tready = 1'b0;
            end
            ST_HASH: begin
                rd_en = !last_cnt;
                hash_ctl.upd = rd_pend_reg;
            end
            ST_FINISH: begin
                s_tready = 1'b0;
            end
            default: s_tready = 1'b0;
        endcase
    end

    // Chunk byte address and write qualification.
    always_comb begin
        if (chunk_pos_reg == 16'd0 && !chunk_rej_reg) begin
            byte_addr = {1'b0, in_coff};
        end else begin
            byte_addr = {1'b0, in_coff} + 33'(chunk_pos_reg);
        end
        put_ok = receiving_reg && byte_addr < 33'(ann_size_reg);
    end

    // Item processing, counters and result formation.
    always_comb begin
        receiving_next   = receiving_reg;
        cur_xfer_next    = cur_xfer_reg;
        cur_owner_next   = cur_owner_reg;
        cur_purpose_next = cur_purpose_reg;
        ann_hash_next    = ann_hash_reg;
        ann_size_next    = ann_size_reg;
        rcv_count_next   = rcv_count_reg;
        chunk_pos_next   = chunk_pos_reg;
        chunk_rej_next   = chunk_rej_reg;
        cnt_next         = cnt_reg;
        rd_pend_next     = 1'b0;
        chunk_write      = 1'b0;
        emit             = 1'b0;
        emit_kind        = RES_ACK;
        emit_xfer        = in_xfer;
        count_sum        = 33'd0;
        ok               = 1'b0;
        m_valid_next     = m_valid_reg && !m_tready;
        m_kind_next      = m_kind_reg;
        m_data_next      = m_data_reg;

        if (state_reg == ST_IDLE && s_fire) begin
            case (in_kind)
                KIND_BEGIN: begin
                    chunk_pos_next = 16'd0;
                    chunk_rej_next = 1'b0;
                    if (in_tsize == 32'd0 || in_tsize > BUF_MAX) begin
                        receiving_next = 1'b0;
                        emit      = 1'b1;
                        emit_kind = RES_REJECTED;
                    end else begin
                        receiving_next   = 1'b1;
                        cur_xfer_next    = in_xfer;
                        cur_owner_next   = in_owner;
                        cur_purpose_next = in_purpose;
                        ann_hash_next    = in_ehash;
                        ann_size_next    = SIZE_W'(in_tsize);
                        rcv_count_next   = 32'd0;
                        cnt_next         = '0;
                    end
                end
                KIND_CHUNK: begin
                    if (chunk_pos_reg == 16'd0 && !chunk_rej_reg) begin
                        if (!receiving_reg || in_xfer != cur_xfer_reg) begin
                            chunk_rej_next = 1'b1;
                        end else if (in_clen == 16'd0
                                || in_coff > 32'(ann_size_reg)
                                || 32'(in_clen) > 32'(ann_size_reg) - in_coff) begin
                            receiving_next = 1'b0;
                            chunk_rej_next = 1'b1;
                            emit      = 1'b1;
                            emit_kind = RES_DROPPED;
                            emit_xfer = cur_xfer_reg;
                        end else begin
                            chunk_write    = put_ok;
                            chunk_pos_next = 16'd1;
                        end
                    end else if (!chunk_rej_reg) begin
                        chunk_write = put_ok && (chunk_pos_reg < in_clen);
                        if (chunk_pos_reg != 16'hFFFF) begin
                            chunk_pos_next = chunk_pos_reg + 16'd1;
                        end
                    end
                    if (s_tlast) begin
                        if (!chunk_rej_next && receiving_next) begin
                            count_sum = {1'b0, rcv_count_reg} + 33'(in_clen);
                            rcv_count_next = count_sum[32] ? 32'hFFFF_FFFF
                                                           : count_sum[31:0];
                        end
                        chunk_pos_next = 16'd0;
                        chunk_rej_next = 1'b0;
                    end
                end
                KIND_DONE: begin
                    chunk_pos_next = 16'd0;
                    chunk_rej_next = 1'b0;
                    if (receiving_reg && in_xfer == cur_xfer_reg) begin
                        receiving_next = 1'b0;
                        cnt_next       = '0;
                    end
                end
                KIND_PEER: begin
                    chunk_pos_next = 16'd0;
                    chunk_rej_next = 1'b0;
                    receiving_next = 1'b0;
                end
                default: receiving_next = 1'b0;
            endcase
        end

        // Clearing pass and hash walk share the counter.
        if (state_reg == ST_CLEAR) begin
            cnt_next = cnt_reg + SIZE_W'(1);
        end
        if (state_reg == ST_HASH && !last_cnt) begin
            cnt_next     = cnt_reg + SIZE_W'(1);
            rd_pend_next = 1'b1;
        end

        // Result register loads.
        if (emit) begin
            m_valid_next = 1'b1;
            m_kind_next  = emit_kind;
            m_data_next  = '0;
            m_data_next[31:0] = emit_xfer;
        end
        if (state_reg == ST_FINISH && out_free) begin
            ok = (rcv_count_reg == 32'(ann_size_reg)) && (hash_val == ann_hash_reg);
            m_valid_next = 1'b1;
            m_kind_next  = RES_ACK;
            m_data_next  = '0;
            m_data_next[31:0]  = cur_xfer_reg;
            m_data_next[32]    = ok;
            m_data_next[64:33] = local_id_reg;
            if (ok) begin
                m_data_next[96:65]   = cur_owner_reg;
                m_data_next[104:97]  = cur_purpose_reg;
                m_data_next[121:105] = REPORT_SIZE_W'(ann_size_reg);
            end
        end
    end

    // Memory port selection.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[AW-1:0];
            wr_data = 8'd0;
        end else begin
            wr_en   = chunk_write;
            wr_addr = byte_addr[AW-1:0];
            wr_data = in_byte;
        end
        rd_addr = cnt_reg[AW-1:0];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            receiving_reg <= 1'b0;
            chunk_pos_reg <= 16'd0;
            chunk_rej_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            local_id_reg  <= 32'd0;
            cur_xfer_reg    <= 32'd0;
            cur_owner_reg   <= 32'd0;
            cur_purpose_reg <= 8'd0;
            ann_hash_reg    <= 32'd0;
            ann_size_reg    <= '0;
            rcv_count_reg   <= 32'd0;
        end else begin
            state_reg     <= state_next;
            receiving_reg <= receiving_next;
            chunk_pos_reg <= chunk_pos_next;
            chunk_rej_reg <= chunk_rej_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                local_id_reg <= cfg_wr_data;
            end
            cur_xfer_reg    <= cur_xfer_next;
            cur_owner_reg   <= cur_owner_next;
            cur_purpose_reg <= cur_purpose_next;
            ann_hash_reg    <= ann_hash_next;
            ann_size_reg    <= ann_size_next;
            rcv_count_reg   <= rcv_count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        m_kind_reg <= m_kind_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_data_reg;

    hctr_mem #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hctr_hash u_hash (
        .aclk     (aclk),
        .ctl      (hash_ctl),
        .data_in  (rd_data),
        .hash_out (hash_val)
    );
endmodule

[rtl/hctr_chk.sv]
// Port checker for the transfer receiver and its bind.
`include "hash_checked_transfer_receiver_macros.svh"

module hctr_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hctr_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);
    import hctr_pkg::*;

    // A stalled result keeps its contents.
    `HCTR_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Only the three defined result kinds leave the block.
    `HCTR_ASSERT_IMP(a_kind, aclk, aresetn, m_tvalid, m_tuser != 2'd3)

    // Reject and drop reports carry only the transfer identifier.
    `HCTR_ASSERT_IMP(a_rep, aclk, aresetn, m_tvalid && m_tuser != RES_ACK, m_tdata[127:32] == '0)

    // A failed acknowledgement reports no file data.
    `HCTR_ASSERT_IMP(a_fail, aclk, aresetn, m_tvalid && m_tuser == RES_ACK && !m_tdata[32], m_tdata[127:65] == '0)
endmodule

bind hash_checked_transfer_receiver hctr_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/tb.sv]
// Self-checking testbench for the hash-checked transfer receiver.
module tb;
    import hctr_pkg::*;

    localparam int unsigned BUF_BYTES = 65536;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // One expected report from the receiver.
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] xfer;
        logic        ok;
        logic [31:0] sender;
        logic [31:0] owner;
        logic [7:0]  purpose;
        logic [16:0] size;
    } report_t;

    // One FNV-1a step.
    function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * HASH_PRIME;
    endfunction

    // Transfer state tracker and report checker.
    class transfer_scoreboard;
        logic [31:0] local_id;
        bit          receiving;
        logic [31:0] cur_xfer, cur_owner, ann_hash, ann_size, rx_count;
        logic [7:0]  cur_purpose;
        logic [15:0] chunk_pos;
        bit          chunk_skip;
        logic [7:0]  file_bytes[BUF_BYTES];
        int unsigned byte_gen[BUF_BYTES];
        int unsigned gen;
        report_t     pending_reports[$];
        int          mismatches;
        int          reports_seen;

        function void init();
            local_id = 0;
            receiving = 0;
            cur_xfer = 0;
            cur_owner = 0;
            ann_hash = 0;
            ann_size = 0;
            rx_count = 0;
            cur_purpose = 0;
            chunk_pos = 0;
            chunk_skip = 0;
            gen = 1;
            mismatches = 0;
            reports_seen = 0;
        endfunction

        function void store_byte(longint unsigned addr, logic [7:0] v);
            if (receiving && addr < ann_size && addr < BUF_BYTES) begin
                file_bytes[addr] = v;
                byte_gen[addr] = gen;
            end
        endfunction

        function logic [31:0] buffer_digest(logic [31:0] n);
            logic [31:0] h;
            h = HASH_BASIS;
            for (longint unsigned i = 0; i < n && i < BUF_BYTES; i++)
                h = fnv_fold(h, (byte_gen[i] == gen) ? file_bytes[i] : 8'd0);
            return h;
        endfunction

        function void push_report(logic [1:0] k, logic [31:0] x, logic ok);
            report_t r;
            r.kind = k;
            r.xfer = x;
            r.ok = ok;
            r.sender = (k == RES_ACK) ? local_id : 32'd0;
            r.owner = ok ? cur_owner : 32'd0;
            r.purpose = ok ? cur_purpose : 8'd0;
            r.size = ok ? ann_size[16:0] : 17'd0;
            pending_reports.push_back(r);
        endfunction

        // Applies one accepted input transaction.
        function void note_item(item_kind_t kind, logic [31:0] xid, logic [31:0] owner,
                                logic [7:0] purpose, logic [31:0] tsize, logic [31:0] ehash,
                                logic [31:0] coff, logic [15:0] clen, logic [7:0] dbyte,
                                logic last);
            longint unsigned sum;
            logic ok;
            case (kind)
                KIND_BEGIN: begin
                    chunk_pos = 0;
                    chunk_skip = 0;
                    if (tsize == 0 || tsize > BUF_BYTES) begin
                        receiving = 0;
                        push_report(RES_REJECTED, xid, 1'b0);
                    end else begin
                        receiving = 1;
                        cur_xfer = xid;
                        cur_owner = owner;
                        cur_purpose = purpose;
                        ann_hash = ehash;
                        ann_size = tsize;
                        rx_count = 0;
                        gen++;
                    end
                end
                KIND_CHUNK: begin
                    if (chunk_pos == 0 && !chunk_skip) begin
                        if (!receiving || xid != cur_xfer) begin
                            chunk_skip = 1;
                        end else if (clen == 0 || coff > ann_size ||
                                     clen > ann_size - coff) begin
                            receiving = 0;
                            chunk_skip = 1;
                            push_report(RES_DROPPED, cur_xfer, 1'b0);
                        end else begin
                            store_byte(coff, dbyte);
                            chunk_pos = 1;
                        end
                    end else if (!chunk_skip) begin
                        if (chunk_pos < clen)
                            store_byte(longint'(coff) + chunk_pos, dbyte);
                        if (chunk_pos != 16'hFFFF)
                            chunk_pos++;
                    end
                    if (last) begin
                        if (!chunk_skip && receiving) begin
                            sum = longint'(rx_count) + clen;
                            rx_count = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                        end
                        chunk_pos = 0;
                        chunk_skip = 0;
                    end
                end
                KIND_DONE: begin
                    chunk_pos = 0;
                    chunk_skip = 0;
                    if (receiving && xid == cur_xfer) begin
                        ok = (rx_count == ann_size) && (buffer_digest(ann_size) == ann_hash);
                        receiving = 0;
                        push_report(RES_ACK, xid, ok);
                    end
                end
                default: begin
                    chunk_pos = 0;
                    chunk_skip = 0;
                    receiving = 0;
                end
            endcase
        endfunction

        function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
        endfunction

        // Compares one accepted report with the oldest expectation.
        function void check_report(logic [1:0] k, logic [OUT_DATA_W-1:0] d);
            report_t r;
            reports_seen++;
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected report, kind", k, 0);
                return;
            end
            r = pending_reports.pop_front();
            if (k != r.kind) report_mismatch("result_kind", k, r.kind);
            if (d[31:0] != r.xfer) report_mismatch("report_xfer_id", d[31:0], r.xfer);
            if (d[32] != r.ok) report_mismatch("ack_ok", d[32], r.ok);
            if (d[64:33] != r.sender) report_mismatch("ack_sender", d[64:33], r.sender);
            if (d[96:65] != r.owner) report_mismatch("report_owner", d[96:65], r.owner);
            if (d[104:97] != r.purpose)
                report_mismatch("report_purpose", d[104:97], r.purpose);
            if (d[121:105] != r.size) report_mismatch("report_size", d[121:105], r.size);
        endfunction
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  cfg_wr_en = 0;
    logic [31:0]           cfg_wr_data = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tlast = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    transfer_scoreboard sb = new();
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;

    hash_checked_transfer_receiver dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Report monitor and run limit.
    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_tvalid && m_tready)
            sb.check_report(m_tuser, m_tdata);
        if (cycles > CYCLE_LIMIT) begin
            $display("Run limit reached");
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one input transaction; called and returning at a falling edge.
    task automatic send_item(item_kind_t kind, logic [31:0] xid, logic [31:0] owner,
                             logic [7:0] purpose, logic [31:0] tsize, logic [31:0] ehash,
                             logic [31:0] coff, logic [15:0] clen, logic [7:0] dbyte,
                             logic last);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
            while ($urandom_range(0, 99) < idle_pct) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tlast <= last;
        s_tdata <= {dbyte, clen, coff, ehash, tsize, purpose, owner, xid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(kind, xid, owner, purpose, tsize, ehash, coff, clen, dbyte, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_begin(logic [31:0] xid, logic [31:0] tsize, logic [31:0] ehash);
        send_item(KIND_BEGIN, xid, $urandom(), $urandom(), tsize, ehash,
                  $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic send_done(logic [31:0] xid);
        send_item(KIND_DONE, xid, $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic send_peer();
        send_item(KIND_PEER, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // Sends nbytes byte items of one chunk, taking content from the file image.
    task automatic send_chunk(logic [31:0] xid, logic [31:0] coff, logic [15:0] clen,
                              int nbytes, ref logic [7:0] image[$]);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++) begin
            b = (longint'(coff) + i < image.size()) ? image[coff + i] : $urandom();
            send_item(KIND_CHUNK, xid, $urandom(), $urandom(), $urandom(), $urandom(),
                      coff, clen, b, i == nbytes - 1);
        end
    endtask

    // Waits until no report is owed and the block takes input again.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_reports.size() != 0) @(negedge aclk);
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_local_id(logic [31:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        sb.local_id = v;
    endtask

    // One transfer with random content, mostly well formed.
    task automatic random_transfer();
        logic [7:0]  image[$];
        logic [31:0] xid, h;
        int          n, pos, len;
        xid = $urandom();
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
        h = HASH_BASIS;
        for (int i = 0; i < n; i++) begin
            image.push_back($urandom());
            h = fnv_fold(h, image[i]);
        end
        send_begin(xid, n, ($urandom_range(0, 9) == 0) ? $urandom() : h);
        pos = 0;
        while (pos < n) begin
            len = $urandom_range(1, (n - pos < 16) ? n - pos : 16);
            case ($urandom_range(0, 39))
                0: ;                                             // gap in the file
                1: send_chunk(xid, pos, len, len + 2, image);    // extra byte items
                2: send_chunk(xid, pos, len, 1, image);          // chunk cut short
                3: send_chunk(xid ^ 32'h1, pos, len, len, image); // stale transfer
                4: send_chunk(xid, $urandom_range(0, n + 4), $urandom(), 2, image);
                5: send_peer();
                6: begin
                    send_chunk(xid, pos, len, len, image);       // overlap
                    send_chunk(xid, pos, len, len, image);
                end
                default: send_chunk(xid, pos, len, len, image);
            endcase
            pos += len;
        end
        send_done(($urandom_range(0, 19) == 0) ? ~xid : xid);
    endtask

    // Random item with random fields; sizes on begin kept small or invalid.
    task automatic noise_item();
        item_kind_t k;
        logic [31:0] tsize;
        k = item_kind_t'($urandom_range(0, 3));
        tsize = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 32);
        send_item(k, ($urandom_range(0, 1) == 0) ? sb.cur_xfer : $urandom(), $urandom(),
                  $urandom(), tsize, $urandom(),
                  ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 40),
                  ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 20),
                  $urandom(), $urandom());
    endtask

    task automatic directed_items();
        logic [7:0] image[$];
        logic [7:0] none[$];
        logic [31:0] h;
        send_begin(32'h0000_0001, 0, 0);                 // zero size rejected
        send_begin(32'hFFFF_FFFF, BUF_BYTES + 1, 0);     // just over the buffer
        send_begin(32'h8000_0000, 32'hFFFF_FFFF, 0);     // largest size
        send_chunk(32'h5, 0, 1, 1, none);                // no open transfer
        send_done(32'h1);                                 // done with nothing open
        send_peer();
        send_begin(32'hA5A5_A5A5, BUF_BYTES, 32'hFFFF_FFFF);
        send_item(KIND_CHUNK, 32'hA5A5_A5A5, 0, 0, 0, 0, BUF_BYTES - 1, 1, 8'hFF, 1);
        send_done(32'hA5A5_A5A5);                         // full buffer hash walk
        image = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        h = HASH_BASIS;
        foreach (image[i]) h = fnv_fold(h, image[i]);
        send_begin(32'h0000_0010, 4, h);
        send_chunk(32'h0000_0011, 0, 4, 4, image);       // stale id, skipped
        send_chunk(32'h0000_0010, 0, 4, 4, image);
        send_done(32'h0000_0010);                         // matching file
        send_begin(32'h0000_0020, 8, 0);
        send_chunk(32'h0000_0020, 0, 0, 1, image);       // zero length drops
        send_begin(32'h0000_0030, 8, 0);
        send_chunk(32'h0000_0030, 9, 1, 1, image);       // offset past the end
        send_begin(32'h0000_0040, 8, 0);
        send_chunk(32'h0000_0040, 4, 16'hFFFF, 1, image); // length past the end
        send_begin(32'h0000_0050, 2, 0);
        send_chunk(32'h0000_0050, 0, 2, 1, image);       // chunk cut short
        send_done(32'h0000_0050);
    endtask

    initial begin
        int unsigned idles[4] = '{0, 53, 0, 8};
        int unsigned stalls[4] = '{0, 0, 53, 8};
        logic [31:0] ids[4] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
        int          target;
        sb.init();
        ids[2] = $urandom();
        ids[3] = $urandom();
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        write_local_id(32'h1234_5678);
        directed_items();
        for (int ph = 0; ph < 4; ph++) begin
            // Phase boundary: the sender holds off until every report is in.
            drain();
            write_local_id(ids[ph]);
            idle_pct = idles[ph];
            stall_pct = stalls[ph];
            target = items_sent + 300;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) < 8) random_transfer();
                else noise_item();
            end
        end
        drain();
        $display("Sent %0d input transactions over four idle/stall phases and checked %0d reports.",
                 items_sent, sb.reports_seen);
        if (sb.pending_reports.size() != 0)
            sb.report_mismatch("reports never received, count", sb.pending_reports.size(), 0);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
